// File: src/lfk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lfk_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int NS = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
    localparam int CW = 36;
    localparam logic signed [CW-1:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [CW-1:0] TWO_PI_Q30 = 36'sd6746518852;
    localparam logic signed [CW-1:0] GAIN_Q30 = 36'sd652032874;
    localparam logic signed [21:0] OUT_MAX = 22'sd1048575;
    localparam logic signed [21:0] OUT_MIN = -22'sd1048576;

    localparam logic [2:0] REG_ABAD = 3'd0;
    localparam logic [2:0] REG_HIP = 3'd1;
    localparam logic [2:0] REG_KNEE = 3'd2;
    localparam logic [2:0] REG_SIDE = 3'd3;
    localparam logic [2:0] REG_MIRROR = 3'd4;
    localparam logic [2:0] REG_OFFX = 3'd5;
    localparam logic [2:0] REG_OFFY = 3'd6;
    localparam logic [2:0] REG_OFFZ = 3'd7;

    function automatic logic signed [CW-1:0] atan_q30(input int i);
        case (i)
            0: atan_q30 = 36'sd843314856;
            1: atan_q30 = 36'sd497837829;
            2: atan_q30 = 36'sd263043836;
            3: atan_q30 = 36'sd133525158;
            4: atan_q30 = 36'sd67021686;
            5: atan_q30 = 36'sd33543515;
            6: atan_q30 = 36'sd16775850;
            7: atan_q30 = 36'sd8388437;
            8: atan_q30 = 36'sd4194282;
            9: atan_q30 = 36'sd2097149;
            10: atan_q30 = 36'sd1048575;
            11: atan_q30 = 36'sd524287;
            12: atan_q30 = 36'sd262143;
            13: atan_q30 = 36'sd131071;
            14: atan_q30 = 36'sd65535;
            15: atan_q30 = 36'sd32767;
            16: atan_q30 = 36'sd16383;
            17: atan_q30 = 36'sd8191;
            18: atan_q30 = 36'sd4095;
            19: atan_q30 = 36'sd2047;
            20: atan_q30 = 36'sd1023;
            21: atan_q30 = 36'sd511;
            22: atan_q30 = 36'sd255;
            23: atan_q30 = 36'sd127;
            default: atan_q30 = '0;
        endcase
    endfunction

    // classified item handed from front to the CORDIC
    typedef struct packed {
        logic                 body;
        logic signed [CW-1:0] t1;
        logic signed [CW-1:0] t2;
        logic signed [CW-1:0] t23;
        logic                 n1;
        logic                 n2;
        logic                 n23;
    } t_item;

    // sin and cos at 2^-16; a full unit (65536) needs the 18th bit
    typedef struct packed {
        logic signed [17:0] s1;
        logic signed [17:0] c1;
        logic signed [17:0] s2;
        logic signed [17:0] c2;
        logic signed [17:0] s23;
        logic signed [17:0] c23;
        logic               body;
    } t_trig;

    // wrap a Q30 angle (|t| < 3*pi) into (-pi, pi], then fold to +-pi/2
    function automatic logic [CW:0] fold(input logic signed [CW-1:0] t0);
        logic signed [CW-1:0] t;
        logic neg;
        t = t0;
        neg = 1'b0;
        if (t > PI_Q30) t = t - TWO_PI_Q30;
        else if (t <= -PI_Q30) t = t + TWO_PI_Q30;
        if (t > HALF_PI_Q30) begin
            t = t - PI_Q30;
            neg = 1'b1;
        end else if (t < -HALF_PI_Q30) begin
            t = t + PI_Q30;
            neg = 1'b1;
        end
        fold = {neg, t};
    endfunction
endpackage
`default_nettype wire

// File: src/lfk_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lfk_front import lfk_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_action,
    input  wire logic signed [15:0] i_angle_abad,
    input  wire logic signed [15:0] i_angle_hip,
    input  wire logic signed [15:0] i_angle_knee,
    output logic                    o_valid,
    output t_item                   o_item
);
    logic signed [CW-1:0] w_t1, w_t2, w_t23;
    logic [CW:0] w_f1, w_f2, w_f23;
    t_item n_item;
    logic r_valid;
    t_item r_item;

    // scale to Q30
    assign w_t1 = CW'(i_angle_abad) <<< 17;
    assign w_t2 = CW'(i_angle_hip) <<< 17;
    assign w_t23 = (CW'(i_angle_hip) + CW'(i_angle_knee)) <<< 17;

    always_comb begin
        w_f1 = fold(w_t1);
        w_f2 = fold(w_t2);
        w_f23 = fold(w_t23);
        n_item.body = i_action;
        n_item.t1 = w_f1[CW-1:0];
        n_item.n1 = w_f1[CW];
        n_item.t2 = w_f2[CW-1:0];
        n_item.n2 = w_f2[CW];
        n_item.t23 = w_f23[CW-1:0];
        n_item.n23 = w_f23[CW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else r_valid <= i_valid;
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item = r_item;
endmodule
`default_nettype wire

// File: src/lfk_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module lfk_cordic import lfk_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_item              i_item,
    output logic                    o_valid,
    output t_trig                   o_trig
);
    // three rotation lanes, each stage registered
    logic signed [CW-1:0] r_x [0:NS][0:2];
    logic signed [CW-1:0] r_y [0:NS][0:2];
    logic signed [CW-1:0] r_z [0:NS][0:2];
    logic r_neg [0:NS][0:2];
    logic r_body [0:NS];
    logic r_v [0:NS];
    logic signed [CW-1:0] w_x [0:2];
    logic signed [CW-1:0] w_y [0:2];
    logic signed [17:0] w_s [0:2];
    logic signed [17:0] w_c [0:2];

    always_ff @(posedge i_clk) begin
        r_x[0][0] <= GAIN_Q30; r_y[0][0] <= '0; r_z[0][0] <= i_item.t1;
        r_x[0][1] <= GAIN_Q30; r_y[0][1] <= '0; r_z[0][1] <= i_item.t2;
        r_x[0][2] <= GAIN_Q30; r_y[0][2] <= '0; r_z[0][2] <= i_item.t23;
        r_neg[0][0] <= i_item.n1;
        r_neg[0][1] <= i_item.n2;
        r_neg[0][2] <= i_item.n23;
        r_body[0] <= i_item.body;
        if (!i_rst_n) r_v[0] <= 1'b0;
        else r_v[0] <= i_valid;
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        for (genvar l = 0; l < 3; l++) begin : g_lane
            always_ff @(posedge i_clk) begin
                if (r_z[s][l] >= 0) begin
                    r_x[s+1][l] <= r_x[s][l] - (r_y[s][l] >>> s);
                    r_y[s+1][l] <= r_y[s][l] + (r_x[s][l] >>> s);
                    r_z[s+1][l] <= r_z[s][l] - atan_q30(s);
                end else begin
                    r_x[s+1][l] <= r_x[s][l] + (r_y[s][l] >>> s);
                    r_y[s+1][l] <= r_y[s][l] - (r_x[s][l] >>> s);
                    r_z[s+1][l] <= r_z[s][l] + atan_q30(s);
                end
                r_neg[s+1][l] <= r_neg[s][l];
            end
        end
        always_ff @(posedge i_clk) begin
            r_body[s+1] <= r_body[s];
            if (!i_rst_n) r_v[s+1] <= 1'b0;
            else r_v[s+1] <= r_v[s];
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_round
        always_comb begin
            w_x[l] = (r_x[NS][l] + CW'(8192)) >>> 14;
            w_y[l] = (r_y[NS][l] + CW'(8192)) >>> 14;
            w_c[l] = r_neg[NS][l] ? -w_x[l][17:0] : w_x[l][17:0];
            w_s[l] = r_neg[NS][l] ? -w_y[l][17:0] : w_y[l][17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= r_v[NS];
        o_trig.s1 <= w_s[0]; o_trig.c1 <= w_c[0];
        o_trig.s2 <= w_s[1]; o_trig.c2 <= w_c[1];
        o_trig.s23 <= w_s[2]; o_trig.c23 <= w_c[2];
        o_trig.body <= r_body[NS];
    end
endmodule
`default_nettype wire

// File: src/lfk_back.sv
`timescale 1ns / 1ps
`default_nettype none
module lfk_back import lfk_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_trig              i_trig,
    input  wire logic [15:0]        i_abad_length,
    input  wire logic [15:0]        i_hip_length,
    input  wire logic [15:0]        i_knee_length,
    input  wire logic [1:0]         i_side_sign,
    input  wire logic               i_mirror,
    input  wire logic signed [19:0] i_offset_x,
    input  wire logic signed [19:0] i_offset_y,
    input  wire logic signed [19:0] i_offset_z,
    output logic                    o_valid,
    output logic signed [20:0]      o_pos_x,
    output logic signed [20:0]      o_pos_y,
    output logic signed [20:0]      o_pos_z,
    output logic                    o_saturated
);
    // stage 1: trig products (Q32)
    logic signed [33:0] r_s1c23, r_c1c23, r_c2s1, r_c1c2;
    logic signed [17:0] r_s1, r_c1, r_s2, r_s23;
    logic r_b1, r_v1;
    // stage 2: length products (Q32)
    logic signed [63:0] r_x2, r_y2, r_z2;
    logic r_b2, r_v2;
    logic signed [17:0] w_l1, w_l2, w_l3;
    logic signed [63:0] w_px, w_py, w_pz;
    logic signed [63:0] w_y2;
    logic signed [21:0] w_rx, w_ry, w_rz;
    logic w_sx, w_sy, w_sz;

    assign w_l1 = i_side_sign[1] ? -$signed({2'b0, i_abad_length}) :
                  i_side_sign[0] ? $signed({2'b0, i_abad_length}) : 18'sd0;
    assign w_l2 = -$signed({2'b0, i_hip_length});
    assign w_l3 = -$signed({2'b0, i_knee_length});

    always_ff @(posedge i_clk) begin
        r_s1c23 <= i_trig.s1 * i_trig.c23;
        r_c1c23 <= i_trig.c1 * i_trig.c23;
        r_c2s1 <= i_trig.c2 * i_trig.s1;
        r_c1c2 <= i_trig.c1 * i_trig.c2;
        r_s1 <= i_trig.s1; r_c1 <= i_trig.c1;
        r_s2 <= i_trig.s2; r_s23 <= i_trig.s23;
        r_b1 <= i_trig.body;
        if (!i_rst_n) r_v1 <= 1'b0;
        else r_v1 <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        r_x2 <= -(64'(w_l3) * 64'(r_s1c23)) + ((64'(w_l1) * 64'(r_c1)) <<< 16)
                - 64'(w_l2) * 64'(r_c2s1);
        r_y2 <= 64'(w_l3) * 64'(r_c1c23) + ((64'(w_l1) * 64'(r_s1)) <<< 16)
                + 64'(w_l2) * 64'(r_c1c2);
        r_z2 <= (64'(w_l3) * 64'(r_s23) + 64'(w_l2) * 64'(r_s2)) <<< 16;
        r_b2 <= r_b1;
        if (!i_rst_n) r_v2 <= 1'b0;
        else r_v2 <= r_v1;
    end

    // mirror y, round, add offset for body-frame items, saturate
    always_comb begin
        w_y2 = i_mirror ? -r_y2 : r_y2;
        w_px = (r_x2 + 64'sh80000000) >>> 32;
        w_py = (w_y2 + 64'sh80000000) >>> 32;
        w_pz = (r_z2 + 64'sh80000000) >>> 32;
        if (r_b2) begin
            w_px = w_px + 64'(i_offset_x);
            w_py = w_py + 64'(i_offset_y);
            w_pz = w_pz + 64'(i_offset_z);
        end
        w_sx = (w_px > 64'(OUT_MAX)) || (w_px < 64'(OUT_MIN));
        w_sy = (w_py > 64'(OUT_MAX)) || (w_py < 64'(OUT_MIN));
        w_sz = (w_pz > 64'(OUT_MAX)) || (w_pz < 64'(OUT_MIN));
        w_rx = w_sx ? (w_px[63] ? OUT_MIN : OUT_MAX) : w_px[21:0];
        w_ry = w_sy ? (w_py[63] ? OUT_MIN : OUT_MAX) : w_py[21:0];
        w_rz = w_sz ? (w_pz[63] ? OUT_MIN : OUT_MAX) : w_pz[21:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= r_v2;
        o_pos_x <= w_rx[20:0];
        o_pos_y <= w_ry[20:0];
        o_pos_z <= w_rz[20:0];
        o_saturated <= w_sx | w_sy | w_sz;
    end
endmodule
`default_nettype wire

// File: src/leg_forward_kinematics_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Foot position of a three-link hexapod leg.
// Input: pulse i_start with the frame choice (i_action) and three joint
// angles; o_busy never rises, so a transaction is taken every cycle.
// Output: o_done strobes for one cycle with o_pos_x/y/z and o_saturated.
// An item passes the front register, the CORDIC input register, one
// register per CORDIC stage, the rounding register, two multiply
// stages and the output register.
// Throughput is one transaction per clock, set by the fully pipelined
// CORDIC lanes and multiplier stages.
// The front classifies each angle (wrap and fold into +-pi/2); the
// CORDIC computes trig and the back the foot position. The pipeline
// registers form the queue between them.
// Reset (synchronous, active low) drops all in-flight transactions and
// loads the register defaults: lengths and offsets zero, side_sign 1.
// The receiver cannot stall: every result appears exactly once.
// Registers sit on the APB port at byte address 4*index; write only
// while idle.
module leg_forward_kinematics_core import lfk_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic               i_action,
    input  wire logic signed [15:0] i_angle_abad,
    input  wire logic signed [15:0] i_angle_hip,
    input  wire logic signed [15:0] i_angle_knee,
    output logic                    o_done,
    output logic signed [20:0]      o_pos_x,
    output logic signed [20:0]      o_pos_y,
    output logic signed [20:0]      o_pos_z,
    output logic                    o_saturated,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [15:0] r_abad, r_hip, r_knee;
    logic [1:0] r_side;
    logic r_mirror;
    logic signed [19:0] r_offx, r_offy, r_offz;
    logic w_wr;
    logic [2:0] w_idx;
    logic f_valid, c_valid;
    t_item f_item;
    t_trig c_trig;

    assign o_busy = 1'b0;
    assign pready = 1'b1;
    assign w_wr = psel & penable & pwrite;
    assign w_idx = paddr[4:2];

    // register file: write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abad <= '0; r_hip <= '0; r_knee <= '0;
            r_side <= 2'b01; r_mirror <= 1'b0;
            r_offx <= '0; r_offy <= '0; r_offz <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_ABAD: r_abad <= pwdata[15:0];
                REG_HIP: r_hip <= pwdata[15:0];
                REG_KNEE: r_knee <= pwdata[15:0];
                REG_SIDE: r_side <= pwdata[1:0];
                REG_MIRROR: r_mirror <= pwdata[0];
                REG_OFFX: r_offx <= pwdata[19:0];
                REG_OFFY: r_offy <= pwdata[19:0];
                REG_OFFZ: r_offz <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // read back, sign-extended where signed
    always_comb begin
        case (w_idx)
            REG_ABAD: prdata = {16'b0, r_abad};
            REG_HIP: prdata = {16'b0, r_hip};
            REG_KNEE: prdata = {16'b0, r_knee};
            REG_SIDE: prdata = {{30{r_side[1]}}, r_side};
            REG_MIRROR: prdata = {31'b0, r_mirror};
            REG_OFFX: prdata = 32'(r_offx);
            REG_OFFY: prdata = 32'(r_offy);
            REG_OFFZ: prdata = 32'(r_offz);
            default: prdata = '0;
        endcase
    end

    lfk_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_start & ~o_busy),
        .i_action(i_action), .i_angle_abad(i_angle_abad),
        .i_angle_hip(i_angle_hip), .i_angle_knee(i_angle_knee),
        .o_valid(f_valid), .o_item(f_item)
    );

    lfk_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .i_item(f_item),
        .o_valid(c_valid), .o_trig(c_trig)
    );

    lfk_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(c_valid), .i_trig(c_trig),
        .i_abad_length(r_abad), .i_hip_length(r_hip), .i_knee_length(r_knee),
        .i_side_sign(r_side), .i_mirror(r_mirror),
        .i_offset_x(r_offx), .i_offset_y(r_offy), .i_offset_z(r_offz),
        .o_valid(o_done), .o_pos_x(o_pos_x), .o_pos_y(o_pos_y),
        .o_pos_z(o_pos_z), .o_saturated(o_saturated)
    );

    // the block never holds the sender off
    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");
    // a clipped coordinate must sit at a rail
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_saturated |->
            o_pos_x == OUT_MAX[20:0] || o_pos_x == OUT_MIN[20:0] ||
            o_pos_y == OUT_MAX[20:0] || o_pos_y == OUT_MIN[20:0] ||
            o_pos_z == OUT_MAX[20:0] || o_pos_z == OUT_MIN[20:0])
        else $error("saturated flag without clipped coordinate");
    a_front_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> f_valid)
        else $error("accepted transaction lost in front");
endmodule
`default_nettype wire
